>>> rtl/mtwe_pkg.sv
// Shared types and constants of the markup text word extractor.
package mtwe_pkg;

    // Tag-name matchers: script, /script, style, /style.
    localparam int NUM_TAGS = 4;
    localparam int TAG_MAX_LEN = 7;

    // Position code of a matcher that waits for the next '<'.
    localparam logic [3:0] MATCH_IDLE = 4'd15;

    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_GT = 8'h3E;

    localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;

    // Characters of each tag name, unused tail positions are zero.
    localparam logic [7:0] TAG_CHAR [NUM_TAGS][TAG_MAX_LEN] = '{
        '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00},
        '{8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74},
        '{8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00, 8'h00},
        '{8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00}
    };

    localparam logic [3:0] TAG_LEN [NUM_TAGS] = '{4'd6, 4'd7, 4'd5, 4'd6};

    // Skip flag changes from the matcher bank for one byte.
    // Bit 0 is the script flag, bit 1 the style flag.
    typedef struct packed {
        logic [1:0] set;
        logic [1:0] clr;
    } flag_upd_t;

    // One result item.
    typedef struct packed {
        logic       kind;
        logic [7:0] letter;
        logic [6:0] word_length;
        logic [7:0] preceding_mark;
    } result_t;

    localparam logic KIND_LETTER   = 1'b0;
    localparam logic KIND_WORD_END = 1'b1;

endpackage

>>> rtl/markup_text_word_extractor.sv
// Top level of the markup text word extractor: input and result registers around the parser.
//
// The block takes one page byte per request and emits the lower-case letters of visible
// text, followed by a word-end request carrying the word length and the latest mark seen at
// that point; text inside tags and inside script and style sections is dropped. One byte is
// processed per clock cycle while the result side is not stalled: a byte is held in the input
// register while the parser and the four tag matchers work on it, and its result, if any,
// lands in the output register. Bytes follow back to back as long as the result side is not
// stalled. chunk_last does not affect the output.
module markup_text_word_extractor
    import mtwe_pkg::*;
#(
    parameter int MAX_WORD_LEN = 127
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       chunk_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] letter,
    output logic [6:0] word_length,
    output logic [7:0] preceding_mark
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       match_en;
    logic       res_valid;
    result_t    res;
    flag_upd_t  flag_upd;

    // The held byte moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
    end

    mtwe_parse #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .flag_upd (flag_upd),
        .match_en (match_en),
        .res_valid(res_valid),
        .res      (res)
    );

    mtwe_tag_match u_tag_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (match_en),
        .in_byte (in_byte_reg),
        .flag_upd(flag_upd)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign letter         = out_reg.letter;
    assign word_length    = out_reg.word_length;
    assign preceding_mark = out_reg.preceding_mark;

endmodule

>>> rtl/mtwe_tag_match.sv
// Bank of four tag-name matchers that set and clear the skip flags.
module mtwe_tag_match
    import mtwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] in_byte,
    output flag_upd_t  flag_upd
);

    logic [NUM_TAGS-1:0] done;

    genvar j;
    generate
        for (j = 0; j < NUM_TAGS; j++)
        begin : g_lane
            logic [3:0] pos_reg;
            logic [3:0] pos_next;
            logic       hit;

            // A lane restarts on '<', advances on a match, else goes idle.
            always_comb
            begin
                pos_next = pos_reg;
                hit      = 1'b0;
                if (in_byte == CHAR_LT)
                begin
                    pos_next = 4'd0;
                end
                else if (pos_reg >= TAG_LEN[j])
                begin
                    pos_next = MATCH_IDLE;
                end
                else if (in_byte != TAG_CHAR[j][pos_reg[2:0]])
                begin
                    pos_next = MATCH_IDLE;
                end
                else if (pos_reg + 4'd1 >= TAG_LEN[j])
                begin
                    pos_next = MATCH_IDLE;
                    hit      = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end

            assign done[j] = en & hit;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pos_reg <= 4'd0;
                end
                else if (en)
                begin
                    pos_reg <= pos_next;
                end
            end
        end
    endgenerate

    // Opening tags set their flag, closing tags clear it.
    assign flag_upd.set = {done[2], done[0]};
    assign flag_upd.clr = {done[3], done[1]};

endmodule

>>> rtl/mtwe_parse.sv
// Per-byte text state: tag depth, skip flags, word length and last mark.
module mtwe_parse
    import mtwe_pkg::*;
#(
    parameter int MAX_WORD_LEN = 127
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  flag_upd_t  flag_upd,
    output logic       match_en,
    output logic       res_valid,
    output result_t    res
);

    localparam int HELD_W = $clog2(MAX_WORD_LEN + 1);

    logic signed [15:0] depth_reg;
    logic signed [15:0] depth_next;
    logic [1:0]         skip_reg;
    logic [1:0]         skip_next;
    logic [HELD_W-1:0]  held_reg;
    logic [HELD_W-1:0]  held_next;
    logic [7:0]         mark_reg;
    logic [7:0]         mark_next;
    logic               match_run;

    // Decode one byte against the current state.
    always_comb
    begin
        logic is_lt;
        logic is_gt;
        logic is_letter;
        logic skipping;
        is_lt     = (in_byte == CHAR_LT);
        is_gt     = (in_byte == CHAR_GT);
        is_letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
                    ((in_byte >= 8'h61) && (in_byte <= 8'h7A));
        skipping  = (skip_reg != 2'b00);

        depth_next = depth_reg;
        held_next  = held_reg;
        mark_next  = mark_reg;
        match_run  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        if (in_byte[7])
        begin
            // High bytes only end the word.
            if (held_reg != '0)
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_WORD_END;
                res.word_length    = 7'(held_reg);
                res.preceding_mark = mark_reg;
            end
            held_next = '0;
        end
        else
        begin
            // Brackets outside skipped sections move the depth.
            if (is_lt && !skipping)
            begin
                if (depth_reg != DEPTH_MAX)
                begin
                    depth_next = depth_reg + 16'sd1;
                end
                if (depth_reg == 16'sd0)
                begin
                    if (held_reg != '0)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_WORD_END;
                        res.word_length    = 7'(held_reg);
                        res.preceding_mark = mark_reg;
                    end
                    held_next = '0;
                end
                mark_next = in_byte;
            end
            else if (is_gt && !skipping)
            begin
                if (depth_reg != DEPTH_MIN)
                begin
                    depth_next = depth_reg - 16'sd1;
                end
                mark_next = in_byte;
            end

            // Visible text at depth zero.
            if (depth_next == 16'sd0 && !skipping)
            begin
                if (is_letter)
                begin
                    if (held_reg < HELD_W'(MAX_WORD_LEN))
                    begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_LETTER;
                        res.letter         = in_byte | 8'h20;
                        res.preceding_mark = mark_next;
                        held_next          = held_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!res_valid && held_reg != '0)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_WORD_END;
                        res.word_length    = 7'(held_reg);
                        res.preceding_mark = mark_next;
                        held_next          = '0;
                    end
                    mark_next = in_byte;
                end
            end

            // Skipped text at depth zero leaves the matchers alone.
            match_run = !(depth_next == 16'sd0 && skipping);
        end
    end

    assign match_en  = step & match_run;
    assign skip_next = (skip_reg | flag_upd.set) & ~flag_upd.clr;

    // State registers advance once per processed byte; the skip flags only while the matchers run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            skip_reg  <= '0;
            held_reg  <= '0;
            mark_reg  <= '0;
        end
        else if (step)
        begin
            depth_reg <= depth_next;
            held_reg  <= held_next;
            mark_reg  <= mark_next;
            if (match_en)
            begin
                skip_reg <= skip_next;
            end
        end
    end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the markup text word extractor, with its own parser predictor.
module tb_top;
    import mtwe_pkg::*;

    localparam int WORD_LIMIT = 127;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} row_check_t;

    typedef struct {
        string      txt;
        int         reps;
        row_check_t chk;
        result_t    want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       chunk_last;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [7:0] letter;
    logic [6:0] word_length;
    logic [7:0] preceding_mark;

    // Parser state as the predictor sees it after every accepted request.
    logic signed [15:0] sc_depth;
    logic [1:0]         sc_skip;
    logic [3:0]         sc_match [NUM_TAGS];
    int                 sc_held;
    logic [7:0]         sc_mark;
    string              tag_name [NUM_TAGS] = '{"script", "/script", "style", "/style"};

    result_t    awaited_tokens[$];
    stim_row_t  stim_table[$];
    logic [7:0] piece[$];

    int  errors = 0;
    int  bytes_sent = 0;
    int  random_start = 0;
    int  results_seen = 0;
    int  word_ends_seen = 0;
    int  input_held_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  squeeze_req = 1'b0;

    markup_text_word_extractor #(.MAX_WORD_LEN(WORD_LIMIT)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .chunk_last    (chunk_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .letter        (letter),
        .word_length   (word_length),
        .preceding_mark(preceding_mark)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back, some short pauses, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A finished word yields a word-end token, an empty one yields nothing.
    function automatic bit close_word(output result_t r);
        r = '0;
        if (sc_held == 0)
            return 1'b0;
        r = '{KIND_WORD_END, 8'h00, sc_held[6:0], sc_mark};
        sc_held = 0;
        return 1'b1;
    endfunction

    // The four tag-name matchers restart on '<' and drop out on the first wrong character.
    function automatic void step_matchers(logic [7:0] c);
        if (c == CHAR_LT)
        begin
            for (int j = 0; j < NUM_TAGS; j++)
                sc_match[j] = '0;
            return;
        end
        for (int j = 0; j < NUM_TAGS; j++)
        begin
            if (sc_match[j] >= tag_name[j].len() || c != tag_name[j][sc_match[j]])
                sc_match[j] = MATCH_IDLE;
            else if (sc_match[j] + 1 >= tag_name[j].len())
            begin
                sc_match[j] = MATCH_IDLE;
                // Even matchers open a section, odd ones close it.
                sc_skip[j / 2] = (j % 2 == 0);
            end
            else
                sc_match[j] = sc_match[j] + 4'd1;
        end
    endfunction

    // Predicts the token, if any, that one page byte produces.
    function automatic bit scan_byte(input logic [7:0] c, output result_t r);
        bit                 got;
        logic signed [15:0] was;
        got = 1'b0;
        r = '0;
        if (c[7])
            return close_word(r);

        // Brackets move the depth only outside skipped sections.
        if (c == CHAR_LT && sc_skip == 2'b00)
        begin
            was = sc_depth;
            if (sc_depth < DEPTH_MAX)
                sc_depth = sc_depth + 16'sd1;
            if (was == 0)
                got = close_word(r);
            sc_mark = c;
        end
        else if (c == CHAR_GT && sc_skip == 2'b00)
        begin
            if (sc_depth > DEPTH_MIN)
                sc_depth = sc_depth - 16'sd1;
            for (int j = 0; j < NUM_TAGS; j++)
                sc_match[j] = MATCH_IDLE;
            sc_mark = c;
        end

        // Visible text: letters extend the word, anything else ends it.
        if (sc_depth == 0)
        begin
            if (sc_skip != 2'b00)
                return got;
            if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            begin
                if (sc_held < WORD_LIMIT)
                begin
                    r = '{KIND_LETTER, c | 8'h20, 7'd0, sc_mark};
                    sc_held++;
                    got = 1'b1;
                end
            end
            else if (!got)
            begin
                got = close_word(r);
                sc_mark = c;
            end
            else
                sc_mark = c;
        end

        step_matchers(c);
        return got;
    endfunction

    task automatic log_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // Appends a token to the list of results still to come.
    function automatic void await_token(result_t r);
        awaited_tokens.insert(awaited_tokens.size(), r);
    endfunction

    // Offers one byte, waits for the request to be taken, then records what it should produce.
    task automatic send_byte(logic [7:0] b, logic last, row_check_t chk, result_t want);
        int      g;
        bit      got;
        result_t r;
        g = no_gaps ? 0 : pick_idle();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        chunk_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        got = scan_byte(b, r);
        case (chk)
            CHK_PREDICT:
                if (got)
                    await_token(r);
            CHK_TYPED:
                await_token(want);
            default:
                ;
        endcase
    endtask

    // The typed check, if any, applies to the last byte of the text.
    task automatic send_text(string t, row_check_t chk, result_t want);
        for (int i = 0; i < t.len(); i++)
            send_byte(t[i], i == t.len() - 1, (i == t.len() - 1) ? chk : CHK_PREDICT, want);
    endtask

    // Closes open sections and tags so that the next fragment starts in visible text.
    // A skip flag at depth zero cannot be left, so that state is left alone.
    task automatic settle_parser();
        while (sc_depth != 0)
        begin
            if (sc_skip[0])
                send_text("</script", CHK_PREDICT, '0);
            else if (sc_skip[1])
                send_text("</style", CHK_PREDICT, '0);
            else if (sc_depth > 0)
                send_text(">", CHK_PREDICT, '0);
            else
                send_text("< ", CHK_PREDICT, '0);
        end
    endtask

    function automatic void add_byte(logic [7:0] b);
        piece.insert(piece.size(), b);
    endfunction

    function automatic void add_text(string t);
        for (int i = 0; i < t.len(); i++)
            add_byte(t[i]);
    endfunction

    function automatic void add_letters(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 25);
            add_byte(8'($urandom_range(0, 1) ? "A" + r : "a" + r));
        end
    endfunction

    function automatic void add_row(string t, int n, row_check_t c, result_t w);
        stim_row_t s;
        s.txt = t;
        s.reps = n;
        s.chk = c;
        s.want = w;
        stim_table.insert(stim_table.size(), s);
    endfunction

    // Random page fragments: mostly well-formed text, tags and sections, some noise.
    task automatic run_random_pages(int target);
        int    pick;
        string name;
        string seps;
        string body;
        string tags [7];
        seps = " .,;:!?-0123456789\n\t'\"&#=";
        body = "ab <>/sxy";
        tags = '{"p", "div", "/p", "a", "br", "span", "h1"};
        while (bytes_sent - random_start < target)
        begin
            if (sc_depth < 0 || $urandom_range(0, 3) == 0)
                settle_parser();
            if (bytes_sent - random_start > 150 && random_start >= 0)
            begin
                squeeze_req = 1'b1;
                random_start = random_start - 1000000;
                target = target + 1000000;
            end
            piece.delete();
            pick = $urandom_range(0, 99);
            if (pick < 30)
                add_letters(($urandom_range(0, 49) == 0) ? $urandom_range(120, 135)
                                                          : $urandom_range(1, 10));
            else if (pick < 48)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_byte(8'($urandom_range(128, 255)));
                else
                    add_byte(seps[$urandom_range(0, seps.len() - 1)]);
            end
            else if (pick < 63)
            begin
                add_text({"<", tags[$urandom_range(0, 6)]});
                if ($urandom_range(0, 2) == 0)
                    add_text(" id=q");
                add_text(">");
            end
            else if (pick < 73)
            begin
                name = $urandom_range(0, 1) ? "script" : "style";
                add_text({"<", name, ">"});
                repeat ($urandom_range(0, 12))
                    add_byte(body[$urandom_range(0, body.len() - 1)]);
                add_text({"</", name, ">"});
            end
            else if (pick < 83)
            begin
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 91)
            begin
                // Broken markup: stray brackets and unfinished tag names.
                case ($urandom_range(0, 3))
                    0: add_text(">");
                    1: add_text("<");
                    2: add_text("<scr");
                    default: add_text("<script");
                endcase
            end
            else
            begin
                add_text("<<b>");
                add_letters(2);
                add_text(">");
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            foreach (piece[i])
                send_byte(piece[i], 1'($urandom_range(0, 1)), CHK_PREDICT, '0);
        end
        no_gaps = 1'b0;
        random_start = random_start + 1000000;
    endtask

    // Stimulus and end of run.
    initial
    begin
        in_valid <= 1'b0;
        in_byte <= 8'h00;
        chunk_last <= 1'b0;
        rst_n <= 1'b0;
        sc_depth = '0;
        sc_skip = '0;
        for (int j = 0; j < NUM_TAGS; j++)
            sc_match[j] = '0;
        sc_held = 0;
        sc_mark = '0;

        // Case folding and separators, read straight off the parser rules.
        add_row("A", 1, CHK_TYPED, '{KIND_LETTER, "a", 7'd0, 8'h00});
        add_row("Z", 1, CHK_TYPED, '{KIND_LETTER, "z", 7'd0, 8'h00});
        add_row("a", 1, CHK_TYPED, '{KIND_LETTER, "a", 7'd0, 8'h00});
        add_row("z", 1, CHK_TYPED, '{KIND_LETTER, "z", 7'd0, 8'h00});
        add_row("\377", 1, CHK_TYPED, '{KIND_WORD_END, 8'h00, 7'd4, 8'h00});
        add_row("@", 1, CHK_NONE, '0);
        add_row("q", 1, CHK_TYPED, '{KIND_LETTER, "q", 7'd0, "@"});
        add_row("[", 1, CHK_TYPED, '{KIND_WORD_END, 8'h00, 7'd1, "@"});
        add_row("`{", 1, CHK_PREDICT, '0);
        add_row("\200", 1, CHK_NONE, '0);
        add_row("b", 1, CHK_TYPED, '{KIND_LETTER, "b", 7'd0, "{"});
        // Negative depth hides text; the '<' back to zero ends the word and is its mark.
        add_row(">", 1, CHK_NONE, '0);
        add_row("c", 1, CHK_NONE, '0);
        add_row("<", 1, CHK_TYPED, '{KIND_WORD_END, 8'h00, 7'd1, CHAR_LT});
        // Script and style sections, nesting and a word that runs past the limit.
        add_row("<script>xy<b>z</script>", 1, CHK_PREDICT, '0);
        add_row("<style>p</style>w.", 1, CHK_PREDICT, '0);
        add_row("<<<div>>>x ", 1, CHK_PREDICT, '0);
        add_row("<script><style>q</script>r</style>s;", 1, CHK_PREDICT, '0);
        add_row("Ab", 65, CHK_PREDICT, '0);
        add_row(",", 1, CHK_TYPED, '{KIND_WORD_END, 8'h00, 7'd127, ";"});
        add_row("<SCRIPT>Up <script>\377</script>", 1, CHK_PREDICT, '0);
        add_row("<scr<style>v</style>>t!", 1, CHK_PREDICT, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            no_gaps = (stim_table[i].reps > 100);
            repeat (stim_table[i].reps)
                send_text(stim_table[i].txt, stim_table[i].chk, stim_table[i].want);
        end
        no_gaps = 1'b0;

        random_start = bytes_sent;
        run_random_pages(500);

        // A section opened right at depth zero locks the parser; only a high byte still ends words.
        settle_parser();
        send_text("><script ab<>.\377xyz", CHK_PREDICT, '0);
        in_valid <= 1'b0;

        while (awaited_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d page bytes, %0d of them random, ending in a locked section.",
                 bytes_sent, bytes_sent - random_start);
        $display("Checked %0d tokens (%0d word ends); input was held off for %0d cycles.",
                 results_seen, word_ends_seen, input_held_cycles);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall, one long hold-off on request, and field checks.
    initial
    begin : rx_side
        int      stall_left;
        int      calm_left;
        result_t w;
        stall_left = 0;
        calm_left = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (awaited_tokens.size() == 0)
                    log_mismatch("token with none awaited, kind", kind, -1);
                else
                begin
                    w = awaited_tokens.pop_front();
                    if (kind === KIND_WORD_END)
                        word_ends_seen++;
                    if (kind !== w.kind)
                        log_mismatch("kind", kind, w.kind);
                    if (letter !== w.letter)
                        log_mismatch("letter", letter, w.letter);
                    if (word_length !== w.word_length)
                        log_mismatch("word_length", word_length, w.word_length);
                    if (preceding_mark !== w.preceding_mark)
                        log_mismatch("preceding_mark", preceding_mark, w.preceding_mark);
                end
            end

            // Long hold-off so that the block fills and stalls its input.
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(50, 200);
                stall_left = (calm_left > 0) ? 0 : pick_idle();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (in_valid === 1'b1 && in_stall === 1'b1)
                input_held_cycles++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
